// ===== hdl/fedl_pkg.sv =====
package fedl_pkg;

    localparam int MaxFrames     = 65536;
    localparam int MaxChannels   = 8;
    localparam int SampleBits    = 24;

    localparam int FrameBits     = $clog2(MaxFrames);
    localparam int CountBits     = FrameBits + 1;
    localparam int ChanBits      = $clog2(MaxChannels);
    localparam int ChanCountBits = 4;
    localparam int AddrBits      = FrameBits + ChanBits;
    localparam int StoreDepth    = MaxFrames * MaxChannels;

    localparam int FracBits      = 16;
    localparam int GainBits      = 17;
    localparam int CfgIndexBits  = 3;
    localparam int CfgDataBits   = 17;

    localparam int DivBits       = CountBits + FrameBits;
    localparam int ReduceSteps   = FrameBits + 1;
    localparam int ReduceCntBits = $clog2(ReduceSteps + 1);

    typedef enum logic [CfgIndexBits-1:0] {
        REG_CHANNEL_COUNT,
        REG_DELAY_FRAMES,
        REG_RING_FRAMES,
        REG_FRAC_OFFSET,
        REG_INTENSITY,
        REG_FEEDBACK
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_REDUCE,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_MIX,
        ST_MAG,
        ST_MUL_I,
        ST_MUL_F,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic load;
        logic cap_a;
        logic mix;
        logic mag;
        logic mul_i;
        logic mul_f;
    } t_arith_ctl;

    typedef struct packed {
        logic                done;
        logic [ChanBits-1:0] ch;
        logic                bend;
    } t_done_info;

endpackage

// ===== hdl/fedl_ram.sv =====
module fedl_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== hdl/fedl_arith.sv =====
module fedl_arith (
    input  logic                                  i_clk,
    input  fedl_pkg::t_arith_ctl                  i_ctl,
    input  logic signed [fedl_pkg::SampleBits-1:0] i_sample_in,
    input  logic signed [fedl_pkg::SampleBits-1:0] i_rdata,
    input  logic [fedl_pkg::FracBits-1:0]         i_frac_offset,
    input  logic [fedl_pkg::GainBits-1:0]         i_intensity,
    input  logic [fedl_pkg::GainBits-1:0]         i_feedback,
    output logic signed [fedl_pkg::SampleBits-1:0] o_y,
    output logic signed [fedl_pkg::SampleBits-1:0] o_wdata
);

    localparam int SB       = fedl_pkg::SampleBits;
    localparam int FB       = fedl_pkg::FracBits;
    localparam int GB       = fedl_pkg::GainBits;
    localparam int EchoBits = SB + FB;
    localparam int MixBits  = SB + FB + 2;
    localparam int PhBits   = GB + SB;
    localparam int PlBits   = GB + FB;
    localparam int TermBits = GB + SB + 1 - FB;
    localparam int SumBits  = TermBits + 2;

    localparam logic [PlBits:0]               RoundBias = (PlBits + 1)'(1) << (2 * FB - 1);
    localparam logic signed [SumBits-1:0]     SatHi     = SumBits'(2 ** (SB - 1) - 1);
    localparam logic signed [SumBits-1:0]     SatLo     = ~SatHi;

    logic signed [SB-1:0]       r_x;
    logic signed [SB-1:0]       r_a;
    logic signed [EchoBits-1:0] r_echo;
    logic [EchoBits-1:0]        r_mag;
    logic                       r_neg;
    logic [PhBits-1:0]          r_ph;
    logic [PlBits-1:0]          r_pl;
    logic signed [SB-1:0]       r_y;

    logic signed [SB:0]         diff;
    logic signed [MixBits-1:0]  prod;
    logic signed [MixBits-1:0]  mix_sum;
    logic [GB-1:0]              gain;
    logic [PlBits:0]            pl_rnd;
    logic [PhBits:0]            acc;
    logic [TermBits-1:0]        q;
    logic signed [TermBits:0]   term;
    logic signed [SumBits-1:0]  sum;
    logic signed [SB-1:0]       sat;

    always_comb begin
        diff    = (SB + 1)'(i_rdata) - (SB + 1)'(r_a);
        prod    = diff * $signed({1'b0, i_frac_offset});
        mix_sum = prod + (MixBits'(r_a) <<< FB);
        gain    = i_ctl.mul_f ? i_feedback : i_intensity;
    end

    // Rounded gain term, ties away from zero, added to the input and saturated.
    always_comb begin
        pl_rnd = {1'b0, r_pl} + RoundBias;
        acc    = {1'b0, r_ph} + (PhBits + 1)'(pl_rnd >> FB);
        q      = acc[PhBits:FB];
        term   = r_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        sum    = SumBits'(term) + SumBits'(r_x);
        if (sum > SatHi) begin
            sat = SatHi[SB-1:0];
        end else if (sum < SatLo) begin
            sat = SatLo[SB-1:0];
        end else begin
            sat = sum[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_sample_in;
        end
        if (i_ctl.cap_a) begin
            r_a <= i_rdata;
        end
        if (i_ctl.mix) begin
            r_echo <= mix_sum[EchoBits-1:0];
        end
        if (i_ctl.mag) begin
            r_neg <= r_echo[EchoBits-1];
            r_mag <= r_echo[EchoBits-1] ? EchoBits'(-r_echo) : EchoBits'(r_echo);
        end
        if (i_ctl.mul_i || i_ctl.mul_f) begin
            r_ph <= gain * r_mag[EchoBits-1:FB];
            r_pl <= gain * r_mag[FB-1:0];
        end
        if (i_ctl.mul_f) begin
            r_y <= sat;
        end
    end

    assign o_y     = r_y;
    assign o_wdata = sat;

endmodule

// ===== hdl/fedl_ctrl.sv =====
module fedl_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fedl_pkg::CfgIndexBits-1:0]   i_cfg_index,
    input  logic [fedl_pkg::CfgDataBits-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_block_end,
    output logic                                o_in_ready,
    input  logic                                i_out_free,
    input  logic [fedl_pkg::SampleBits-1:0]     i_wdata,
    output fedl_pkg::t_arith_ctl                o_arith_ctl,
    output fedl_pkg::t_done_info                o_done,
    output logic [fedl_pkg::FracBits-1:0]       o_frac_offset,
    output logic [fedl_pkg::GainBits-1:0]       o_intensity,
    output logic [fedl_pkg::GainBits-1:0]       o_feedback,
    output logic                                o_mem_we,
    output logic [fedl_pkg::AddrBits-1:0]       o_mem_addr,
    output logic [fedl_pkg::SampleBits-1:0]     o_mem_wdata
);

    localparam int FrB = fedl_pkg::FrameBits;
    localparam int CnB = fedl_pkg::CountBits;
    localparam int ChB = fedl_pkg::ChanBits;
    localparam int CcB = fedl_pkg::ChanCountBits;

    logic [CcB-1:0]                      r_channel_count;
    logic [CnB-1:0]                      r_delay_frames;
    logic [CnB-1:0]                      r_ring_frames;
    logic [fedl_pkg::FracBits-1:0]       r_frac_offset;
    logic [fedl_pkg::GainBits-1:0]       r_intensity;
    logic [fedl_pkg::GainBits-1:0]       r_feedback;

    fedl_pkg::t_state                    r_state;
    fedl_pkg::t_state                    n_state;
    logic [fedl_pkg::AddrBits-1:0]       r_clr_addr;
    logic [FrB-1:0]                      r_wf;
    logic [ChB-1:0]                      r_ch;
    logic [fedl_pkg::ReduceCntBits-1:0]  r_red_cnt;
    logic [fedl_pkg::DivBits-1:0]        r_div;
    logic [FrB-1:0]                      r_tap;
    logic                                r_bend;

    logic [CcB-1:0]  nch;
    logic [CnB-1:0]  ring;
    logic [CnB-1:0]  dl;
    logic [CnB:0]    tap_sum;
    logic [FrB-1:0]  tap_a;
    logic [CnB-1:0]  tap_b_inc;
    logic [FrB-1:0]  tap_b;
    logic [CnB-1:0]  wf_inc;
    logic [FrB-1:0]  wf_next;
    logic [CcB-1:0]  ch_inc;
    logic            frame_end;
    logic            wf_ok;
    logic            in_acc;
    logic            done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CcB'(1);
            r_delay_frames  <= CnB'(1);
            r_ring_frames   <= CnB'(1);
            r_frac_offset   <= '0;
            r_intensity     <= '0;
            r_feedback      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fedl_pkg::REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CcB-1:0];
                fedl_pkg::REG_DELAY_FRAMES:  r_delay_frames  <= i_cfg_data[CnB-1:0];
                fedl_pkg::REG_RING_FRAMES:   r_ring_frames   <= i_cfg_data[CnB-1:0];
                fedl_pkg::REG_FRAC_OFFSET:   r_frac_offset   <= i_cfg_data[fedl_pkg::FracBits-1:0];
                fedl_pkg::REG_INTENSITY:     r_intensity     <= i_cfg_data[fedl_pkg::GainBits-1:0];
                fedl_pkg::REG_FEEDBACK:      r_feedback      <= i_cfg_data[fedl_pkg::GainBits-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_channel_count == '0) begin
            nch = CcB'(1);
        end else if (r_channel_count > CcB'(fedl_pkg::MaxChannels)) begin
            nch = CcB'(fedl_pkg::MaxChannels);
        end else begin
            nch = r_channel_count;
        end

        if (r_ring_frames == '0) begin
            ring = CnB'(1);
        end else if (r_ring_frames > CnB'(fedl_pkg::MaxFrames)) begin
            ring = CnB'(fedl_pkg::MaxFrames);
        end else begin
            ring = r_ring_frames;
        end

        if (r_delay_frames == '0) begin
            dl = CnB'(1);
        end else if (r_delay_frames > ring) begin
            dl = ring;
        end else begin
            dl = r_delay_frames;
        end

        tap_sum = {2'b00, r_wf} + {1'b0, ring - dl};
        if (tap_sum >= {1'b0, ring}) begin
            tap_sum = tap_sum - {1'b0, ring};
        end
        tap_a = tap_sum[FrB-1:0];

        tap_b_inc = {1'b0, r_tap} + CnB'(1);
        tap_b     = (tap_b_inc == ring) ? '0 : tap_b_inc[FrB-1:0];

        wf_inc  = {1'b0, r_wf} + CnB'(1);
        wf_next = (wf_inc == ring) ? '0 : wf_inc[FrB-1:0];

        ch_inc    = CcB'(r_ch) + CcB'(1);
        frame_end = (ch_inc >= nch) || r_bend;
        wf_ok     = {1'b0, r_wf} < ring;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fedl_pkg::ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = fedl_pkg::ST_IDLE;
                end
            end
            fedl_pkg::ST_REDUCE: begin
                if (r_red_cnt == fedl_pkg::ReduceCntBits'(1)) begin
                    n_state = fedl_pkg::ST_IDLE;
                end
            end
            fedl_pkg::ST_IDLE: begin
                if (!wf_ok) begin
                    n_state = fedl_pkg::ST_REDUCE;
                end else if (i_in_valid) begin
                    n_state = fedl_pkg::ST_RD_A;
                end
            end
            fedl_pkg::ST_RD_A:  n_state = fedl_pkg::ST_RD_B;
            fedl_pkg::ST_RD_B:  n_state = fedl_pkg::ST_MIX;
            fedl_pkg::ST_MIX:   n_state = fedl_pkg::ST_MAG;
            fedl_pkg::ST_MAG:   n_state = fedl_pkg::ST_MUL_I;
            fedl_pkg::ST_MUL_I: n_state = fedl_pkg::ST_MUL_F;
            fedl_pkg::ST_MUL_F: n_state = fedl_pkg::ST_WRITE;
            fedl_pkg::ST_WRITE: begin
                if (i_out_free) begin
                    n_state = fedl_pkg::ST_IDLE;
                end
            end
            default: n_state = fedl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == fedl_pkg::ST_IDLE) && wf_ok;
        in_acc     = o_in_ready && i_in_valid;
        done       = (r_state == fedl_pkg::ST_WRITE) && i_out_free;

        o_arith_ctl.load  = in_acc;
        o_arith_ctl.cap_a = (r_state == fedl_pkg::ST_RD_B);
        o_arith_ctl.mix   = (r_state == fedl_pkg::ST_MIX);
        o_arith_ctl.mag   = (r_state == fedl_pkg::ST_MAG);
        o_arith_ctl.mul_i = (r_state == fedl_pkg::ST_MUL_I);
        o_arith_ctl.mul_f = (r_state == fedl_pkg::ST_MUL_F);

        o_done.done = done;
        o_done.ch   = r_ch;
        o_done.bend = r_bend;

        o_mem_we    = 1'b0;
        o_mem_addr  = {r_wf, r_ch};
        o_mem_wdata = i_wdata;
        case (r_state)
            fedl_pkg::ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = r_clr_addr;
                o_mem_wdata = '0;
            end
            fedl_pkg::ST_RD_A:  o_mem_addr = {r_tap, r_ch};
            fedl_pkg::ST_RD_B:  o_mem_addr = {tap_b, r_ch};
            fedl_pkg::ST_WRITE: o_mem_we   = done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fedl_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_wf       <= '0;
            r_ch       <= '0;
            r_red_cnt  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == fedl_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + fedl_pkg::AddrBits'(1);
            end
            if ((r_state == fedl_pkg::ST_IDLE) && !wf_ok) begin
                r_red_cnt <= fedl_pkg::ReduceCntBits'(fedl_pkg::ReduceSteps);
            end
            if (r_state == fedl_pkg::ST_REDUCE) begin
                r_red_cnt <= r_red_cnt - fedl_pkg::ReduceCntBits'(1);
                if ({{(fedl_pkg::DivBits - FrB){1'b0}}, r_wf} >= r_div) begin
                    r_wf <= r_wf - r_div[FrB-1:0];
                end
            end
            if (done) begin
                if (frame_end) begin
                    r_ch <= '0;
                    r_wf <= wf_next;
                end else begin
                    r_ch <= ch_inc[ChB-1:0];
                end
            end
        end
    end

    // The write frame is brought below a shortened ring by restoring reduction.
    always_ff @(posedge i_clk) begin
        if ((r_state == fedl_pkg::ST_IDLE) && !wf_ok) begin
            r_div <= {ring, FrB'(0)};
        end else if (r_state == fedl_pkg::ST_REDUCE) begin
            r_div <= r_div >> 1;
        end
        if (in_acc) begin
            r_tap  <= tap_a;
            r_bend <= i_block_end;
        end
    end

    assign o_frac_offset = r_frac_offset;
    assign o_intensity   = r_intensity;
    assign o_feedback    = r_feedback;

endmodule

// ===== hdl/feedback_echo_delay_line.sv =====
// Channel   Signals                                        Handshake
// config    i_cfg_we, i_cfg_index, i_cfg_data              write on i_cfg_we, no wait
// input     i_sample_in, i_block_end                       i_in_valid / o_in_ready
// output    o_sample_out, o_channel_index, o_block_end_out o_out_valid / i_out_ready
//
// Each word passes through acceptance, two tap reads on the single delay store port,
// the tap blend multiply, the magnitude step, one step per gain on a shared multiplier
// pair, and the write back into the store.
// After reset a clearing pass writes all 524288 store entries, one per cycle, before
// the first word is accepted; configuration writes are taken throughout.
// A write position beyond a shortened ring holds the input while it is detected in the
// idle state and then brought below the ring by restoring reduction.
// A result waiting in the output register holds the write back step until it is taken.
module feedback_echo_delay_line (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [fedl_pkg::CfgIndexBits-1:0]        i_cfg_index,
    input  logic [fedl_pkg::CfgDataBits-1:0]         i_cfg_data,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic signed [fedl_pkg::SampleBits-1:0]   i_sample_in,
    input  logic                                     i_block_end,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [fedl_pkg::SampleBits-1:0]   o_sample_out,
    output logic [fedl_pkg::ChanBits-1:0]            o_channel_index,
    output logic                                     o_block_end_out
);

    fedl_pkg::t_arith_ctl                    arith_ctl;
    fedl_pkg::t_done_info                    done_info;
    logic [fedl_pkg::FracBits-1:0]           frac_offset;
    logic [fedl_pkg::GainBits-1:0]           intensity;
    logic [fedl_pkg::GainBits-1:0]           feedback;
    logic                                    mem_we;
    logic [fedl_pkg::AddrBits-1:0]           mem_addr;
    logic [fedl_pkg::SampleBits-1:0]         mem_wdata;
    logic [fedl_pkg::SampleBits-1:0]         mem_rdata;
    logic signed [fedl_pkg::SampleBits-1:0]  y;
    logic signed [fedl_pkg::SampleBits-1:0]  wdata;
    logic                                    out_free;

    logic                                    r_out_valid;
    logic signed [fedl_pkg::SampleBits-1:0]  r_sample_out;
    logic [fedl_pkg::ChanBits-1:0]           r_channel_index;
    logic                                    r_block_end_out;

    assign out_free = !r_out_valid || i_out_ready;

    fedl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_block_end   (i_block_end),
        .o_in_ready    (o_in_ready),
        .i_out_free    (out_free),
        .i_wdata       (wdata),
        .o_arith_ctl   (arith_ctl),
        .o_done        (done_info),
        .o_frac_offset (frac_offset),
        .o_intensity   (intensity),
        .o_feedback    (feedback),
        .o_mem_we      (mem_we),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata)
    );

    fedl_ram #(
        .Width (fedl_pkg::SampleBits),
        .Depth (fedl_pkg::StoreDepth)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    fedl_arith u_arith (
        .i_clk         (i_clk),
        .i_ctl         (arith_ctl),
        .i_sample_in   (i_sample_in),
        .i_rdata       (mem_rdata),
        .i_frac_offset (frac_offset),
        .i_intensity   (intensity),
        .i_feedback    (feedback),
        .o_y           (y),
        .o_wdata       (wdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_info.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_info.done) begin
            r_sample_out    <= y;
            r_channel_index <= done_info.ch;
            r_block_end_out <= done_info.bend;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_out    = r_sample_out;
    assign o_channel_index = r_channel_index;
    assign o_block_end_out = r_block_end_out;

`ifndef ASSERT_OFF
    a_one_word_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Input taken while a word is still in progress.");

    a_done_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_info.done |=> o_out_valid)
        else $error("Finished word did not reach the output register.");

    a_no_input_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_in_ready)
        else $error("Input taken before the delay store was cleared.");
`endif

endmodule
